>>> rtl/timed_output_with_chirp_and_auto_off_macros.svh
// Assertion macros for the timed output block.
// Included by modules that carry concurrent checks; needs i_clk and i_rst_n in scope.
`ifndef TIMED_OUTPUT_WITH_CHIRP_AND_AUTO_OFF_MACROS_SVH
`define TIMED_OUTPUT_WITH_CHIRP_AND_AUTO_OFF_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked out of reset
`define TOCAO_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tocao check failed");

// Next-cycle implication, checked out of reset
`define TOCAO_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tocao check failed");

`else

`define TOCAO_ASSERT_IMPL(label, ante, cons)
`define TOCAO_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> rtl/tocao_pkg.sv
// Shared types and codes for the timed output with chirp and auto-off.
// No dependencies; imported by tocao_step and the top level.
package tocao_pkg;

    // request codes
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_CLICK = 2'd1;
    localparam logic [1:0] REQ_SET   = 2'd2;
    localparam logic [1:0] REQ_START = 2'd3;

    // chirp sequencer phases
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_P1_ON  = 3'd1;
    localparam logic [2:0] PH_P1_OFF = 3'd2;
    localparam logic [2:0] PH_P2_ON  = 3'd3;
    localparam logic [2:0] PH_P2_OFF = 3'd4;
    localparam logic [2:0] PH_RUN    = 3'd5;

    // end causes
    localparam logic [1:0] CAUSE_NONE  = 2'd0;
    localparam logic [1:0] CAUSE_TIMED = 2'd1;
    localparam logic [1:0] CAUSE_AUTO  = 2'd2;

    // configuration register indexes
    localparam int         CFG_IDX_W       = 4;
    localparam logic [3:0] CFG_ACTIVE_LOW  = 4'd0;
    localparam logic [3:0] CFG_AUTO_OFF_MS = 4'd1;

    // chirp step lengths in ms
    localparam logic [7:0] CHIRP_ON_MS  = 8'd150;
    localparam logic [7:0] CHIRP_OFF_MS = 8'd120;

    typedef struct packed {
        logic [1:0]  req_type;
        logic        set_active;
        logic [31:0] duration_ms;
        logic        chirp_enable;
    } t_in_item;

    typedef struct packed {
        logic        pin_level;
        logic        is_active;
        logic        timed_active;
        logic [31:0] remaining_ms;
        logic        state_changed;
        logic [1:0]  end_cause;
    } t_out_item;

    typedef struct packed {
        logic        on_flag;
        logic        timed_flag;
        logic [2:0]  chirp_phase;
        logic [31:0] on_elapsed;
        logic [7:0]  step_elapsed;
        logic [31:0] run_length;
        logic        drive_on;
    } t_state;

    typedef struct packed {
        logic        active_low;
        logic [31:0] auto_off_ms;
    } t_cfg;

endpackage

>>> rtl/tocao_step.sv
// Next-state and result logic for one request of the timed output.
// Purely combinational; depends on tocao_pkg.
module tocao_step (
    input  tocao_pkg::t_state    i_state,
    input  tocao_pkg::t_in_item  i_item,
    input  tocao_pkg::t_cfg      i_cfg,
    output tocao_pkg::t_state    o_state,
    output tocao_pkg::t_out_item o_result
);
    import tocao_pkg::*;

    t_state      s;
    logic        changed;
    logic [1:0]  cause;
    logic        want;
    logic [31:0] total;
    logic        use_total;

    always_comb begin
        s       = i_state;
        changed = 1'b0;
        cause   = CAUSE_NONE;
        want    = 1'b0;

        unique case (i_item.req_type)
            REQ_TICK: begin
                // advance saturating counters while on
                if (s.on_flag) begin
                    if (s.on_elapsed != '1) s.on_elapsed = s.on_elapsed + 32'd1;
                    if (s.step_elapsed != '1) s.step_elapsed = s.step_elapsed + 8'd1;
                end
                if (s.on_flag && s.timed_flag) begin
                    unique case (s.chirp_phase)
                        PH_P1_ON: begin
                            if (s.step_elapsed >= CHIRP_ON_MS) begin
                                s.chirp_phase  = PH_P1_OFF;
                                s.step_elapsed = '0;
                                s.drive_on     = 1'b0;
                            end
                        end
                        PH_P1_OFF: begin
                            if (s.step_elapsed >= CHIRP_OFF_MS) begin
                                s.chirp_phase  = PH_P2_ON;
                                s.step_elapsed = '0;
                                s.drive_on     = 1'b1;
                            end
                        end
                        PH_P2_ON: begin
                            if (s.step_elapsed >= CHIRP_ON_MS) begin
                                s.chirp_phase  = PH_P2_OFF;
                                s.step_elapsed = '0;
                                s.drive_on     = 1'b0;
                            end
                        end
                        PH_P2_OFF: begin
                            // end of chirp: expiry is not tested on this tick
                            if (s.step_elapsed >= CHIRP_OFF_MS) begin
                                s.chirp_phase  = PH_RUN;
                                s.step_elapsed = '0;
                                s.drive_on     = 1'b1;
                            end
                        end
                        PH_RUN: begin
                            if (s.on_elapsed >= s.run_length) begin
                                s.on_flag      = 1'b0;
                                s.timed_flag   = 1'b0;
                                s.chirp_phase  = PH_IDLE;
                                s.drive_on     = 1'b0;
                                s.step_elapsed = '0;
                                changed        = 1'b1;
                                cause          = CAUSE_TIMED;
                            end
                        end
                        default: ;
                    endcase
                end else if (s.on_flag && (i_cfg.auto_off_ms != '0)
                             && (s.on_elapsed >= i_cfg.auto_off_ms)) begin
                    // safety timeout for untimed on periods
                    s.on_flag      = 1'b0;
                    s.timed_flag   = 1'b0;
                    s.chirp_phase  = PH_IDLE;
                    s.drive_on     = 1'b0;
                    s.step_elapsed = '0;
                    changed        = 1'b1;
                    cause          = CAUSE_AUTO;
                end
            end
            REQ_CLICK, REQ_SET: begin
                want = (i_item.req_type == REQ_CLICK) ? !s.on_flag : i_item.set_active;
                if (!want) begin
                    changed        = s.on_flag;
                    s.on_flag      = 1'b0;
                    s.timed_flag   = 1'b0;
                    s.chirp_phase  = PH_IDLE;
                    s.drive_on     = 1'b0;
                    s.step_elapsed = '0;
                end else if (!s.on_flag) begin
                    s.on_flag    = 1'b1;
                    s.on_elapsed = '0;
                    s.drive_on   = 1'b1;
                    changed      = 1'b1;
                end else begin
                    // already on: force drive, chirp keeps its phase
                    s.drive_on = 1'b1;
                end
            end
            REQ_START: begin
                s.on_flag      = 1'b1;
                s.on_elapsed   = '0;
                s.drive_on     = 1'b1;
                s.timed_flag   = 1'b1;
                s.run_length   = i_item.duration_ms;
                s.step_elapsed = '0;
                s.chirp_phase  = i_item.chirp_enable ? PH_P1_ON : PH_RUN;
                changed        = 1'b1;
            end
            default: ;
        endcase
    end

    // remaining time: one subtract against the run length or the timeout
    always_comb begin
        total     = s.timed_flag ? s.run_length : i_cfg.auto_off_ms;
        use_total = s.on_flag && (s.timed_flag || (i_cfg.auto_off_ms != '0));
    end

    assign o_state                = s;
    assign o_result.pin_level     = s.drive_on ^ i_cfg.active_low;
    assign o_result.is_active     = s.on_flag;
    assign o_result.timed_active  = s.on_flag && s.timed_flag;
    assign o_result.remaining_ms  = (use_total && (s.on_elapsed < total))
                                    ? (total - s.on_elapsed) : '0;
    assign o_result.state_changed = changed;
    assign o_result.end_cause     = cause;

endmodule

>>> rtl/timed_output_with_chirp_and_auto_off.sv
// Top level of the timed output with start chirp and safety auto-off.
// Depends on tocao_pkg, tocao_step and timed_output_with_chirp_and_auto_off_macros.svh.
//
//  channel | direction | handshake            | payload
//  in      | sink      | i_in_valid/o_in_stall | i_in_data  (t_in_item)
//  out     | source    | o_out_valid/i_out_stall | o_out_data (t_out_item)
//  cfg     | sink      | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// One request per cycle sustained while the output is not stalled: an input register
// feeds the step logic, whose result and new channel state load together into the
// output register, from which the result is offered.
// A stalled result holds the output register, and the input register then fills
// and raises o_in_stall. Synchronous active-low reset clears the channel state,
// both configuration registers and the valid flags; no clearing pass is needed.
`include "timed_output_with_chirp_and_auto_off_macros.svh"

module timed_output_with_chirp_and_auto_off (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  tocao_pkg::t_in_item            i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output tocao_pkg::t_out_item           o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tocao_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data
);
    import tocao_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    t_state    r_state;
    t_cfg      r_cfg;

    t_state    n_state;
    t_out_item n_out;
    logic      advance;
    logic      in_ready;

    // handshake control
    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign in_ready    = !r_in_valid || advance;
    assign o_in_stall  = !in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    tocao_step u_step (
        .i_state  (r_state),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // result register and channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_state     <= '{on_flag: 1'b0, timed_flag: 1'b0, chirp_phase: PH_IDLE,
                             on_elapsed: '0, step_elapsed: '0, run_length: '0,
                             drive_on: 1'b0};
        end else if (advance) begin
            r_out_valid <= 1'b1;
            r_state     <= n_state;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_ACTIVE_LOW:  r_cfg.active_low  <= i_cfg_data[0];
                CFG_AUTO_OFF_MS: r_cfg.auto_off_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // channel off means drive off and chirp idle
    `TOCAO_ASSERT_IMPL(a_off_idle, !r_state.on_flag, !r_state.drive_on && (r_state.chirp_phase == PH_IDLE))
    // a fired end cause always reports a change to off
    `TOCAO_ASSERT_IMPL(a_cause_off, r_out_valid && (r_out.end_cause != CAUSE_NONE), r_out.state_changed && !r_out.is_active)
    // held input request does not move while the result side is blocked
    `TOCAO_ASSERT_NEXT(a_in_hold, r_in_valid && !advance, r_in_valid && $stable(r_in))
    // state only changes when a request passes to the result register
    `TOCAO_ASSERT_NEXT(a_state_hold, !advance, $stable(r_state))

endmodule

>>> bench/timed_output_with_chirp_and_auto_off_tb.sv
// Testbench for timed_output_with_chirp_and_auto_off: a directed opening and then random
// request sequences, checked result by result against a predictor kept in the bench.
// Depends on tocao_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module timed_output_with_chirp_and_auto_off_tb;
    import tocao_pkg::*;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_in_item             i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]          i_cfg_data = '0;

    // requests waiting to be driven, and the status words the block owes us
    t_in_item    req_backlog[$];
    t_out_item   due_status[$];
    int unsigned queued_cnt = 0;
    int unsigned sent_cnt = 0;
    int unsigned mon_cycle = 0;
    int unsigned fault_cnt = 0;
    int unsigned in_wait = 0;
    int unsigned out_wait = 0;

    // predicted channel state and register copies
    logic        ch_on;
    logic        ch_timed;
    logic [2:0]  ch_phase;
    logic [31:0] ch_elapsed;
    logic [7:0]  ch_step;
    logic [31:0] ch_run_len;
    logic        ch_drive;
    logic        cfg_low;
    logic [31:0] cfg_auto_off;

    timed_output_with_chirp_and_auto_off dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------- predictor

    function automatic void chirp_advance(logic [7:0] step_len, logic [2:0] nxt, logic drv);
        if (ch_step >= step_len) begin
            ch_phase = nxt;
            ch_step  = '0;
            ch_drive = drv;
        end
    endfunction

    function automatic void chan_off();
        ch_on    = 1'b0;
        ch_timed = 1'b0;
        ch_phase = PH_IDLE;
        ch_drive = 1'b0;
        ch_step  = '0;
    endfunction

    function automatic void chan_on();
        ch_on      = 1'b1;
        ch_elapsed = '0;
        ch_drive   = 1'b1;
    endfunction

    function automatic logic [31:0] time_left(logic [31:0] total);
        return (ch_elapsed >= total) ? 32'd0 : total - ch_elapsed;
    endfunction

    // apply one request to the channel copy and return the status it produces
    function automatic t_out_item next_status(t_in_item it);
        t_out_item st;
        logic      want;
        st = '0;
        case (it.req_type)
            REQ_TICK: begin
                // counters hold at all ones
                if (ch_on) begin
                    if (ch_elapsed != '1) ch_elapsed = ch_elapsed + 32'd1;
                    if (ch_step != '1) ch_step = ch_step + 8'd1;
                end
                if (ch_on && ch_timed) begin
                    case (ch_phase)
                        PH_P1_ON:  chirp_advance(CHIRP_ON_MS, PH_P1_OFF, 1'b0);
                        PH_P1_OFF: chirp_advance(CHIRP_OFF_MS, PH_P2_ON, 1'b1);
                        PH_P2_ON:  chirp_advance(CHIRP_ON_MS, PH_P2_OFF, 1'b0);
                        PH_P2_OFF: chirp_advance(CHIRP_OFF_MS, PH_RUN, 1'b1);
                        PH_RUN: begin
                            if (ch_elapsed >= ch_run_len) begin
                                chan_off();
                                st.state_changed = 1'b1;
                                st.end_cause     = CAUSE_TIMED;
                            end
                        end
                        default: ;
                    endcase
                end else if (ch_on && cfg_auto_off != 0 && ch_elapsed >= cfg_auto_off) begin
                    chan_off();
                    st.state_changed = 1'b1;
                    st.end_cause     = CAUSE_AUTO;
                end
            end
            REQ_CLICK, REQ_SET: begin
                want = (it.req_type == REQ_CLICK) ? !ch_on : it.set_active;
                if (!want) begin
                    if (ch_on) st.state_changed = 1'b1;
                    chan_off();
                end else if (!ch_on) begin
                    chan_on();
                    st.state_changed = 1'b1;
                end else begin
                    // already on: only the drive is forced, chirp phase untouched
                    ch_drive = 1'b1;
                end
            end
            default: begin
                chan_on();
                ch_timed   = 1'b1;
                ch_run_len = it.duration_ms;
                ch_step    = '0;
                ch_phase   = it.chirp_enable ? PH_P1_ON : PH_RUN;
                st.state_changed = 1'b1;
            end
        endcase
        if (ch_on) begin
            if (ch_timed) st.remaining_ms = time_left(ch_run_len);
            else if (cfg_auto_off != 0) st.remaining_ms = time_left(cfg_auto_off);
        end
        st.pin_level    = ch_drive ^ cfg_low;
        st.is_active    = ch_on;
        st.timed_active = ch_on && ch_timed;
        return st;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        fault_cnt++;
        if (fault_cnt <= 50)
            $display("%0t: mismatch on %s, got %0h, expected %0h", $realtime, what, got, want);
    endtask

    task automatic check_result(t_out_item got);
        t_out_item want;
        if (due_status.size() == 0) begin
            report_mismatch("result with no request pending", 32'd0, 32'd0);
            return;
        end
        want = due_status.pop_front();
        if (got.pin_level !== want.pin_level)
            report_mismatch("pin_level", 32'(got.pin_level), 32'(want.pin_level));
        if (got.is_active !== want.is_active)
            report_mismatch("is_active", 32'(got.is_active), 32'(want.is_active));
        if (got.timed_active !== want.timed_active)
            report_mismatch("timed_active", 32'(got.timed_active), 32'(want.timed_active));
        if (got.remaining_ms !== want.remaining_ms)
            report_mismatch("remaining_ms", got.remaining_ms, want.remaining_ms);
        if (got.state_changed !== want.state_changed)
            report_mismatch("state_changed", 32'(got.state_changed), 32'(want.state_changed));
        if (got.end_cause !== want.end_cause)
            report_mismatch("end_cause", 32'(got.end_cause), 32'(want.end_cause));
    endtask

    // idle length: mostly none, some short, a few long; none at all in calm stretches
    function automatic int unsigned idle_len(bit calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ---------------------------------------------------------------- driver

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_wait = 0;
            chan_off();
            ch_elapsed   = '0;
            ch_run_len   = '0;
            cfg_low      = 1'b0;
            cfg_auto_off = '0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                due_status.push_back(next_status(i_in_data));
                sent_cnt++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (in_wait != 0 || req_backlog.size() == 0) begin
                    if (in_wait != 0) in_wait--;
                    i_in_valid <= 1'b0;
                end else begin
                    i_in_data  <= req_backlog.pop_front();
                    i_in_valid <= 1'b1;
                    in_wait = idle_len((sent_cnt % 300) < 60);
                end
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            out_wait = 0;
        end else begin
            mon_cycle++;
            if (o_out_valid && !i_out_stall) check_result(o_out_data);
            if (out_wait == 0 && $urandom_range(0, 3) == 0)
                out_wait = idle_len((mon_cycle % 700) < 150);
            if (out_wait != 0) begin
                out_wait--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    function automatic t_in_item rand_item(logic [1:0] kind);
        t_in_item it;
        it.req_type     = kind;
        it.set_active   = 1'($urandom_range(0, 1));
        it.duration_ms  = $urandom;
        it.chirp_enable = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic void queue_item(t_in_item it);
        req_backlog.push_back(it);
        queued_cnt++;
    endfunction

    function automatic void queue_req(logic [1:0] kind);
        queue_item(rand_item(kind));
    endfunction

    function automatic void queue_set(logic on);
        t_in_item it;
        it = rand_item(REQ_SET);
        it.set_active = on;
        queue_item(it);
    endfunction

    function automatic void queue_start(logic [31:0] dur, logic chirp);
        t_in_item it;
        it = rand_item(REQ_START);
        it.duration_ms  = dur;
        it.chirp_enable = chirp;
        queue_item(it);
    endfunction

    // ticks, optionally with a stray click, set or restart mixed in
    function automatic void queue_ticks(int unsigned n, bit stray);
        for (int unsigned i = 0; i < n; i++) begin
            if (stray && $urandom_range(0, 19) == 0)
                queue_req(2'($urandom_range(REQ_CLICK, REQ_START)));
            queue_req(REQ_TICK);
        end
    endfunction

    // full chirp run, with the drive forced on during each off step
    function automatic void queue_full_chirp();
        int unsigned dur;
        int unsigned n;
        dur = $urandom_range(0, 600);
        n = ((dur > 541) ? dur : 541) + $urandom_range(0, 3);
        queue_start(dur, 1'b1);
        for (int unsigned i = 1; i <= n; i++) begin
            if (i == 200 || i == 480) queue_set(1'b1);
            queue_req(REQ_TICK);
        end
    endfunction

    // well-formed runs with random content, plus some noise
    task automatic random_mix(int unsigned budget);
        int unsigned base;
        int unsigned pick;
        int unsigned dur;
        base = queued_cnt;
        while (queued_cnt - base < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                dur = $urandom_range(0, 12);
                queue_start(dur, 1'b0);
                queue_ticks(dur + $urandom_range(0, 3), 1'b1);
            end else if (pick < 65) begin
                if ($urandom_range(0, 1)) queue_req(REQ_CLICK);
                else queue_set(1'b1);
                if (cfg_auto_off != 0 && cfg_auto_off <= 40)
                    queue_ticks(cfg_auto_off + $urandom_range(0, 2), 1'b1);
                else
                    queue_ticks($urandom_range(1, 15), 1'b1);
            end else if (pick < 80) begin
                if ($urandom_range(0, 1)) queue_req(REQ_CLICK);
                else queue_set(1'b0);
                queue_ticks($urandom_range(0, 3), 1'b0);
            end else begin
                repeat ($urandom_range(1, 4)) queue_req(2'($urandom_range(0, 3)));
            end
        end
    endtask

    // wait until every request has been accepted and answered, then let the pipeline settle
    task automatic drain();
        while (sent_cnt != queued_cnt || due_status.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_ACTIVE_LOW:  cfg_low = val[0];
            CFG_AUTO_OFF_MS: cfg_auto_off = val;
            default: ;
        endcase
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed opening, reset register values
        queue_req(REQ_TICK);             // tick while off
        queue_req(REQ_CLICK);            // click on
        queue_ticks(2, 1'b0);
        queue_req(REQ_CLICK);            // click off
        queue_set(1'b1);
        queue_set(1'b1);                 // set on while on
        queue_set(1'b0);
        queue_set(1'b0);                 // set off while off
        queue_start(32'd0, 1'b0);        // zero length run ends on its first tick
        queue_req(REQ_TICK);
        queue_start(32'd2, 1'b0);
        queue_start(32'hFFFF_FFFF, 1'b0); // restart while on
        queue_ticks(2, 1'b0);
        queue_set(1'b0);                 // cancel the run
        queue_start(32'hFFFF_FFFF, 1'b1);
        queue_ticks(2, 1'b0);
        queue_set(1'b1);                 // drive forced during first pulse
        queue_req(REQ_CLICK);
        queue_start(32'd3, 1'b0);
        queue_ticks(4, 1'b0);

        drain();
        write_reg(CFG_ACTIVE_LOW, 32'd1);
        write_reg(CFG_AUTO_OFF_MS, 32'd1);
        random_mix(100);

        drain();
        write_reg(CFG_ACTIVE_LOW, 32'hFFFF_FFFE);
        write_reg(CFG_AUTO_OFF_MS, 32'hFFFF_FFFF);
        random_mix(100);

        // safety timeout short, must not cut the chirp run
        drain();
        write_reg(CFG_ACTIVE_LOW, 32'd1);
        write_reg(CFG_AUTO_OFF_MS, $urandom_range(2, 25));
        queue_full_chirp();
        random_mix(80);

        drain();
        write_reg(CFG_AUTO_OFF_MS, 32'd0);
        random_mix(100);

        // chirp cut short by a set off
        drain();
        write_reg(CFG_ACTIVE_LOW, {$urandom} & 32'hFFFF_FFFE);
        write_reg(CFG_AUTO_OFF_MS, $urandom);
        queue_start($urandom, 1'b1);
        queue_ticks(160, 1'b0);
        queue_set(1'b1);
        queue_ticks($urandom_range(0, 140), 1'b0);
        queue_set(1'b0);
        random_mix(80);

        drain();
        write_reg(CFG_ACTIVE_LOW, 32'd1);
        write_reg(CFG_AUTO_OFF_MS, $urandom_range(2, 25));
        random_mix(100);

        drain();
        if (fault_cnt == 0 && due_status.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
